>>> design/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies.
`default_nettype none
package ffba_pkg;
  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);
  localparam int unsigned AddrW = 32;
  localparam logic [31:0] PoolReset = 32'd65536;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_NO_FIT = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [IdxW-1:0] addr;
    logic [31:0]     wr_off;
    logic [31:0]     wr_size;
    logic            wr_free;
  } ffba_cmd_t;

  typedef struct packed {
    logic [31:0] rd_off;
    logic [31:0] rd_size;
    logic        rd_free;
  } ffba_sts_t;
endpackage
`default_nettype wire

>>> design/ffba_table.sv
// Block table datapath: three arrays with one write and one registered read port.
// Depends on ffba_pkg.
`default_nettype none
module ffba_table
  import ffba_pkg::*;
(
  input  wire       clk_i,
  input  ffba_cmd_t cmd_i,
  output ffba_sts_t sts_o
);
  logic [31:0] off_mem [MaxBlocks];
  logic [31:0] size_mem [MaxBlocks];
  logic        free_mem [MaxBlocks];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) begin
      off_mem[cmd_i.addr] <= cmd_i.wr_off;
      size_mem[cmd_i.addr] <= cmd_i.wr_size;
      free_mem[cmd_i.addr] <= cmd_i.wr_free;
    end
    if (cmd_i.op == OP_READ) begin
      sts_o.rd_off <= off_mem[cmd_i.addr];
      sts_o.rd_size <= size_mem[cmd_i.addr];
      sts_o.rd_free <= free_mem[cmd_i.addr];
    end
  end
endmodule
`default_nettype wire

>>> design/ffba_ctrl.sv
// Sequencer for allocate and free requests: scan, shift, merge.
// Depends on ffba_pkg; drives the ffba_table port.
`default_nettype none
module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         command_i,
  input  wire  [31:0] req_size_i,
  input  wire  [4:0]  align_log2_i,
  input  wire  [31:0] blk_offset_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_offset_o,
  output logic [31:0] out_size_o,
  input  wire         pool_wr_i,
  input  wire  [31:0] pool_size_i,
  output ffba_cmd_t   cmd_o,
  input  ffba_sts_t   sts_i
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_RD = 4'd2;
  localparam logic [3:0] S_CHK = 4'd3;
  localparam logic [3:0] S_SHR = 4'd4;   // read j-erase_n-1 for shift towards end
  localparam logic [3:0] S_SHW = 4'd5;
  localparam logic [3:0] S_PUT = 4'd6;   // write allocation entries
  localparam logic [3:0] S_FNB = 4'd7;   // read neighbour
  localparam logic [3:0] S_FNC = 4'd8;
  localparam logic [3:0] S_SLR = 4'd9;   // read j+erase_n for shift towards start
  localparam logic [3:0] S_SLW = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;

  logic [3:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [1:0] step_q, step_d;
  logic cmd_q;
  logic [31:0] req_q, boff_q;
  logic [4:0] lg_q;
  logic [31:0] e_off_q, e_size_q, e_off_d, e_size_d;
  logic [31:0] pad_q, pad_d, left_q, left_d, acc_q, acc_d;
  logic prev_free_q, prev_free_d, e_free_q, e_free_d;
  logic [CntW-1:0] shift_lo_q, shift_lo_d;
  logic [1:0] erase_n_q, erase_n_d;
  logic [2:0] st_q, st_d;
  logic [31:0] ooff_q, ooff_d, osize_q, osize_d;
  logic out_v_q, out_v_d;
  logic pend_q, pend_d;
  logic [31:0] pool_q;
  // previous entry, latched while scanning a free request
  logic [31:0] pool_prev_q, prev_off_q;
  // result held for the output handshake
  logic [2:0] res_st_q;
  logic [31:0] res_off_q, res_size_q;

  logic [31:0] amask, pad_c, left_c;
  logic fits_c;
  assign amask = (32'd1 << lg_q) - 32'd1;
  assign pad_c = (~sts_i.rd_off + 32'd1) & amask;
  assign fits_c = sts_i.rd_size >= pad_c && (sts_i.rd_size - pad_c) >= req_q;
  assign left_c = sts_i.rd_size - pad_c - req_q;

  assign in_ready_o = (state_q == S_IDLE) && !pend_q;
  assign out_valid_o = out_v_q;
  assign status_o = res_st_q;
  assign out_offset_o = res_off_q;
  assign out_size_o = res_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q <= '0;
      out_v_q <= 1'b0;
      pend_q <= 1'b0;
      pool_q <= PoolReset;
      i_q <= '0;
      j_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_v_q <= out_v_d;
      pend_q <= pend_d;
      i_q <= i_d;
      j_q <= j_d;
      step_q <= step_d;
      if (pool_wr_i) pool_q <= pool_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      req_q <= req_size_i;
      lg_q <= align_log2_i;
      boff_q <= blk_offset_i;
    end
    e_off_q <= e_off_d;
    e_size_q <= e_size_d;
    e_free_q <= e_free_d;
    pad_q <= pad_d;
    left_q <= left_d;
    acc_q <= acc_d;
    prev_free_q <= prev_free_d;
    shift_lo_q <= shift_lo_d;
    erase_n_q <= erase_n_d;
    st_q <= st_d;
    ooff_q <= ooff_d;
    osize_q <= osize_d;
    if (state_q == S_OUT && (!out_v_q || out_ready_i)) begin
      res_st_q <= st_q;
      res_off_q <= ooff_q;
      res_size_q <= osize_q;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; step_d = step_q;
    e_off_d = e_off_q; e_size_d = e_size_q; e_free_d = e_free_q;
    pad_d = pad_q; left_d = left_q; acc_d = acc_q; prev_free_d = prev_free_q;
    shift_lo_d = shift_lo_q; erase_n_d = erase_n_q;
    st_d = st_q; ooff_d = ooff_q; osize_d = osize_q;
    out_v_d = out_v_q; pend_d = pend_q;
    cmd_o = '0;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (pool_wr_i) begin
          state_d = S_INIT;
        end else if (in_valid_i && !pend_q) begin
          pend_d = 1'b1;
          i_d = '0;
          prev_free_d = 1'b0;
          ooff_d = '0; osize_d = '0;
          if (!command_i && req_size_i > pool_q) begin
            st_d = ST_TOO_LARGE; state_d = S_OUT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_INIT: begin
        cmd_o.op = OP_WRITE; cmd_o.addr = '0;
        cmd_o.wr_off = '0; cmd_o.wr_size = pool_q; cmd_o.wr_free = 1'b1;
        cnt_d = CntW'(1);
        state_d = pool_wr_i ? S_INIT : S_IDLE;
      end
      S_RD: begin
        if (i_q >= cnt_q) begin
          st_d = cmd_q ? ST_NOT_FOUND : ST_NO_FIT; state_d = S_OUT;
        end else begin
          cmd_o.op = OP_READ; cmd_o.addr = i_q[IdxW-1:0];
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        e_off_d = sts_i.rd_off; e_size_d = sts_i.rd_size; e_free_d = sts_i.rd_free;
        state_d = S_RD;
        i_d = i_q + CntW'(1);
        if (!cmd_q) begin
          if (sts_i.rd_free && fits_c) begin
            pad_d = pad_c; left_d = left_c;
            if (32'(cnt_q) + 32'(left_c != 0) + 32'(pad_c != 0) > 32'(MaxBlocks)) begin
              st_d = ST_FULL; state_d = S_OUT;
            end else begin
              i_d = i_q;
              step_d = 2'd0;
              j_d = cnt_q + CntW'(left_c != 0) + CntW'(pad_c != 0);
              // lowest index to shift; erase_n counts new slots after i (tail) and at i (head)
              shift_lo_d = i_q + CntW'(1) - CntW'(pad_c != 0);
              cnt_d = cnt_q + CntW'(left_c != 0) + CntW'(pad_c != 0);
              erase_n_d = 2'(left_c != 0) + 2'(pad_c != 0);
              state_d = S_SHR;
            end
          end
        end else begin
          if (!sts_i.rd_free && sts_i.rd_off > boff_q) begin
            st_d = ST_NOT_FOUND; state_d = S_OUT;
          end else if (!sts_i.rd_free && sts_i.rd_off == boff_q) begin
            i_d = i_q;
            if (sts_i.rd_size != req_q) begin
              st_d = ST_MISMATCH; state_d = S_OUT;
            end else begin
              acc_d = sts_i.rd_size; erase_n_d = 2'd0; step_d = 2'd0;
              state_d = S_FNB;
            end
          end else begin
            prev_free_d = sts_i.rd_free;
            acc_d = sts_i.rd_size;  // remember previous entry's size
          end
        end
      end
      // shift entries [shift_lo, old cnt) up by erase_n_q slots
      S_SHR: begin
        if (j_q - CntW'(erase_n_q) + CntW'(1) <= shift_lo_q + CntW'(0) ||
            j_q < CntW'(erase_n_q) + shift_lo_q + CntW'(1)) begin
          state_d = S_PUT; step_d = 2'd0;
        end else begin
          cmd_o.op = OP_READ; cmd_o.addr = IdxW'(j_q - CntW'(erase_n_q) - CntW'(1));
          state_d = S_SHW;
        end
      end
      S_SHW: begin
        cmd_o.op = OP_WRITE; cmd_o.addr = IdxW'(j_q - CntW'(1));
        cmd_o.wr_off = sts_i.rd_off; cmd_o.wr_size = sts_i.rd_size;
        cmd_o.wr_free = sts_i.rd_free;
        j_d = j_q - CntW'(1);
        state_d = S_SHR;
      end
      S_PUT: begin
        cmd_o.op = OP_WRITE;
        step_d = step_q + 2'd1;
        priority case (step_q)
          2'd0: begin
            if (pad_q != 0) begin
              cmd_o.addr = i_q[IdxW-1:0];
              cmd_o.wr_off = e_off_q; cmd_o.wr_size = pad_q; cmd_o.wr_free = 1'b1;
            end else cmd_o.op = OP_NONE;
          end
          2'd1: begin
            cmd_o.addr = IdxW'(i_q + CntW'(pad_q != 0));
            cmd_o.wr_off = e_off_q + pad_q; cmd_o.wr_size = req_q; cmd_o.wr_free = 1'b0;
          end
          default: begin
            if (left_q != 0) begin
              cmd_o.addr = IdxW'(i_q + CntW'(pad_q != 0) + CntW'(1));
              cmd_o.wr_off = e_off_q + pad_q + req_q; cmd_o.wr_size = left_q;
              cmd_o.wr_free = 1'b1;
            end else cmd_o.op = OP_NONE;
            st_d = ST_OK; ooff_d = e_off_q + pad_q; osize_d = req_q;
            state_d = S_OUT;
          end
        endcase
      end
      S_FNB: begin
        if (i_q + CntW'(1) < cnt_q) begin
          cmd_o.op = OP_READ; cmd_o.addr = IdxW'(i_q + CntW'(1));
          state_d = S_FNC;
        end else begin
          e_free_d = 1'b0;
          state_d = S_FNC;
        end
      end
      S_FNC: begin
        // acc_q holds the freed size; prev size kept in pool_prev_q only if prev free
        begin
          logic nf;
          logic [31:0] sum;
          nf = (i_q + CntW'(1) < cnt_q) && sts_i.rd_free;
          sum = acc_q + (nf ? sts_i.rd_size : 32'd0);
          cmd_o.op = OP_WRITE;
          if (prev_free_q) begin
            cmd_o.addr = IdxW'(i_q - CntW'(1));
            cmd_o.wr_off = prev_off_q; cmd_o.wr_size = sum + pool_prev_q;
            cmd_o.wr_free = 1'b1;
            shift_lo_d = i_q;
            erase_n_d = nf ? 2'd2 : 2'd1;
          end else begin
            cmd_o.addr = i_q[IdxW-1:0];
            cmd_o.wr_off = boff_q; cmd_o.wr_size = sum; cmd_o.wr_free = 1'b1;
            shift_lo_d = i_q + CntW'(1);
            erase_n_d = nf ? 2'd1 : 2'd0;
          end
          j_d = prev_free_q ? i_q : i_q + CntW'(1);
          st_d = ST_OK;
          state_d = S_SLR;
        end
      end
      S_SLR: begin
        if (erase_n_q == 2'd0 || 32'(j_q) + 32'(erase_n_q) >= 32'(cnt_q)) begin
          cnt_d = cnt_q - CntW'(erase_n_q);
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_READ; cmd_o.addr = IdxW'(j_q + CntW'(erase_n_q));
          state_d = S_SLW;
        end
      end
      S_SLW: begin
        cmd_o.op = OP_WRITE; cmd_o.addr = j_q[IdxW-1:0];
        cmd_o.wr_off = sts_i.rd_off; cmd_o.wr_size = sts_i.rd_size;
        cmd_o.wr_free = sts_i.rd_free;
        j_d = j_q + CntW'(1);
        state_d = S_SLR;
      end
      S_OUT: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1; pend_d = 1'b0; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CHK && cmd_q && (sts_i.rd_free || sts_i.rd_off != boff_q)) begin
      pool_prev_q <= sts_i.rd_free ? sts_i.rd_size : 32'd0;
      prev_off_q <= sts_i.rd_off;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBlocks))
    else $error("entry count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_q)
    else $error("ready while request pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_v_d && !out_v_q) |=> state_q == S_IDLE)
    else $error("result not followed by idle");
endmodule
`default_nettype wire

>>> design/first_fit_block_allocator.sv
// First-fit block allocator: takes one allocate or free request at a time and
// returns one status. A request reads and checks each table entry that it scans
// and reads and writes each entry shifted on insert or erase (at most 64 entries),
// one access at a time on the block table command; after reset or a pool_size
// write the table is rebuilt as one free entry. Depends on ffba_pkg, ffba_ctrl and ffba_table.
`default_nettype none
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         command_i,
  input  wire  [31:0] req_size_i,
  input  wire  [4:0]  align_log2_i,
  input  wire  [31:0] blk_offset_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_offset_o,
  output logic [31:0] out_size_o
);
  ffba_cmd_t cmd;
  ffba_sts_t sts;
  logic pool_wr;
  logic [31:0] pool_q;

  assign pready = 1'b1;
  assign pool_wr = psel && penable && pwrite && paddr == 2'd0;
  assign prdata = (paddr == 2'd0) ? pool_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pool_q <= PoolReset;
    else if (pool_wr) pool_q <= pwdata;
  end

  ffba_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .req_size_i,
    .align_log2_i, .blk_offset_i, .out_valid_o, .out_ready_i, .status_o,
    .out_offset_o, .out_size_o, .pool_wr_i(pool_wr), .pool_size_i(pwdata),
    .cmd_o(cmd), .sts_i(sts)
  );

  ffba_table u_table (.clk_i, .cmd_i(cmd), .sts_o(sts));
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for first_fit_block_allocator: directed table then random requests, checked
// against the row's expected result or a behavioural allocator table. Depends on ffba_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import ffba_pkg::*;

  localparam bit CMD_ALLOC = 1'b0;
  localparam bit CMD_FREE = 1'b1;
  localparam logic [1:0] REG_POOL = 2'd0;
  localparam int WatchLimit = 200000;

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 0, in_ready_o;
  logic command_i = 0;
  logic [31:0] req_size_i = '0, blk_offset_i = '0;
  logic [4:0] align_log2_i = '0;
  logic out_valid_o, out_ready_i = 0;
  logic [2:0] status_o;
  logic [31:0] out_offset_o, out_size_o;

  first_fit_block_allocator dut (.*);

  initial forever #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [2:0] st;
    logic [31:0] off;
    logic [31:0] size;
  } alloc_res_t;

  // behavioural copy of the block table
  logic [31:0] pool_bytes;
  logic [31:0] tbl_off[MaxBlocks];
  logic [31:0] tbl_size[MaxBlocks];
  bit tbl_free[MaxBlocks];
  int tbl_count;
  alloc_res_t pending_q[$];
  int n_err = 0, n_seen = 0, idle_cycles = 0, n_ok = 0;
  logic [31:0] live_off[$], live_size[$];

  function automatic void table_reset(logic [31:0] p);
    pool_bytes = p;
    tbl_off[0] = 0; tbl_size[0] = p; tbl_free[0] = 1; tbl_count = 1;
  endfunction

  function automatic void open_slot(int pos);
    for (int j = tbl_count; j > pos; j--) begin
      tbl_off[j] = tbl_off[j-1]; tbl_size[j] = tbl_size[j-1]; tbl_free[j] = tbl_free[j-1];
    end
    tbl_count++;
  endfunction

  function automatic void close_slot(int pos);
    for (int j = pos; j + 1 < tbl_count; j++) begin
      tbl_off[j] = tbl_off[j+1]; tbl_size[j] = tbl_size[j+1]; tbl_free[j] = tbl_free[j+1];
    end
    tbl_count--;
  endfunction

  function automatic alloc_res_t predict_alloc(bit cmd, logic [31:0] rq, logic [4:0] lg,
                                               logic [31:0] bo);
    alloc_res_t r;
    logic [31:0] al, o, s, pad, left;
    int need;
    r = '{st: ST_NO_FIT, off: 0, size: 0};
    if (cmd == CMD_ALLOC) begin
      if (rq > pool_bytes) begin
        r.st = ST_TOO_LARGE; return r;
      end
      al = 32'd1 << lg;
      for (int i = 0; i < tbl_count; i++) begin
        if (!tbl_free[i]) continue;
        o = tbl_off[i]; s = tbl_size[i];
        pad = (al - (o & (al - 32'd1))) & (al - 32'd1);
        if (s < pad || s - pad < rq) continue;
        left = s - pad - rq;
        need = int'(left > 0) + int'(pad > 0);
        if (tbl_count + need > MaxBlocks) begin
          r.st = ST_FULL; return r;
        end
        if (left > 0) begin
          open_slot(i + 1);
          tbl_off[i+1] = o + pad + rq; tbl_size[i+1] = left; tbl_free[i+1] = 1;
        end
        tbl_off[i] = o + pad; tbl_size[i] = rq; tbl_free[i] = 0;
        if (pad > 0) begin
          open_slot(i);
          tbl_off[i] = o; tbl_size[i] = pad; tbl_free[i] = 1;
        end
        r = '{st: ST_OK, off: o + pad, size: rq};
        return r;
      end
      return r;
    end
    r.st = ST_NOT_FOUND;
    for (int i = 0; i < tbl_count; i++) begin
      bit pf, nf;
      if (tbl_free[i] || tbl_off[i] < bo) continue;
      if (tbl_off[i] > bo) break;
      if (tbl_size[i] != rq) begin
        r.st = ST_MISMATCH; return r;
      end
      tbl_free[i] = 1;
      pf = i > 0 && tbl_free[i-1];
      nf = i + 1 < tbl_count && tbl_free[i+1];
      if (pf && nf) begin
        tbl_size[i-1] = tbl_size[i-1] + tbl_size[i] + tbl_size[i+1];
        close_slot(i); close_slot(i);
      end else if (pf) begin
        tbl_size[i-1] = tbl_size[i-1] + tbl_size[i];
        close_slot(i);
      end else if (nf) begin
        tbl_size[i] = tbl_size[i] + tbl_size[i+1];
        close_slot(i + 1);
      end
      r.st = ST_OK;
      return r;
    end
    return r;
  endfunction

  // valid is dropped only when a real gap follows, so back-to-back requests keep it high
  task automatic gap(int lim);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, lim) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_request(bit cmd, logic [31:0] rq, logic [4:0] lg, logic [31:0] bo,
                              bit has_exp, alloc_res_t exp_res);
    alloc_res_t p;
    gap(30);
    p = predict_alloc(cmd, rq, lg, bo);
    if (has_exp && p != exp_res)
      $display("note: table row disagrees with predictor");
    pending_q = {pending_q, (has_exp ? exp_res : p)};
    if (cmd == CMD_ALLOC && p.st == ST_OK) begin
      live_off = {live_off, p.off}; live_size = {live_size, p.size};
    end
    in_valid_i <= 1; command_i <= cmd; req_size_i <= rq;
    align_log2_i <= lg; blk_offset_i <= bo;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_pool(logic [31:0] v);
    psel <= 1; pwrite <= 1; paddr <= REG_POOL; pwdata <= v; penable <= 0;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    table_reset(v);
    live_off.delete(); live_size.delete();
    @(posedge clk_i);
  endtask

  // result side: random stall, compare against oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        alloc_res_t e;
        n_seen++;
        if (pending_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result st=%0d", status_o);
        end else begin
          e = pending_q.pop_front();
          if (e.st != status_o || e.off != out_offset_o || e.size != out_size_o) begin
            n_err++;
            if (n_err <= 10)
              $display("result %0d: exp st=%0d off=%h size=%h got st=%0d off=%h size=%h",
                       n_seen, e.st, e.off, e.size, status_o, out_offset_o, out_size_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on accepted requests, results or register accesses
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("first_fit_block_allocator: mismatch");
      $finish;
    end
  end

  typedef struct {
    bit cmd;
    logic [31:0] rq;
    logic [4:0] lg;
    logic [31:0] bo;
    bit has_exp;
    alloc_res_t res;
  } stim_row_t;

  stim_row_t dir_tbl[] = '{
    '{CMD_ALLOC, 32'd65537, 5'd0, 32'd0, 1, '{ST_TOO_LARGE, 32'd0, 32'd0}},
    '{CMD_ALLOC, 32'd100, 5'd0, 32'd0, 1, '{ST_OK, 32'd0, 32'd100}},
    '{CMD_ALLOC, 32'd0, 5'd0, 32'd0, 0, '{0, 0, 0}},
    '{CMD_ALLOC, 32'd64, 5'd8, 32'd0, 1, '{ST_OK, 32'd256, 32'd64}},
    '{CMD_FREE, 32'd99, 5'd0, 32'd0, 1, '{ST_MISMATCH, 32'd0, 32'd0}},
    '{CMD_FREE, 32'd100, 5'd0, 32'd1, 1, '{ST_NOT_FOUND, 32'd0, 32'd0}},
    '{CMD_FREE, 32'd100, 5'd0, 32'd0, 1, '{ST_OK, 32'd0, 32'd0}},
    '{CMD_ALLOC, 32'd16, 5'd31, 32'd0, 0, '{0, 0, 0}},
    '{CMD_ALLOC, 32'd65536, 5'd0, 32'd0, 1, '{ST_NO_FIT, 32'd0, 32'd0}},
    '{CMD_FREE, 32'd64, 5'd0, 32'd256, 0, '{0, 0, 0}},
    '{CMD_FREE, 32'd0, 5'd0, 32'd100, 0, '{0, 0, 0}},
    '{CMD_ALLOC, 32'd65536, 5'd0, 32'hFFFF_FFFF, 1, '{ST_NO_FIT, 32'd0, 32'd0}},
    '{CMD_FREE, 32'd65536, 5'd31, 32'd0, 1, '{ST_MISMATCH, 32'd0, 32'd0}},
    '{CMD_ALLOC, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 1, '{ST_TOO_LARGE, 32'd0, 32'd0}}
  };

  task automatic random_request(int small_pool);
    bit cmd;
    int k;
    logic [31:0] rq, bo;
    logic [4:0] lg;
    if (live_off.size() != 0 && $urandom_range(0, 99) < 45) begin
      k = $urandom_range(0, live_off.size() - 1);
      bo = live_off[k]; rq = live_size[k];
      case ($urandom_range(0, 9))
        0: rq = rq ^ (32'd1 << $urandom_range(0, 31));
        1: bo = bo + 32'd1;
        default: begin
          live_off.delete(k); live_size.delete(k);
        end
      endcase
      send_request(CMD_FREE, rq, 5'($urandom), bo, 0, '0);
    end else if ($urandom_range(0, 19) == 0) begin
      send_request(CMD_FREE, $urandom, 5'($urandom), $urandom, 0, '0);
    end else begin
      rq = small_pool ? $urandom_range(0, pool_bytes / 8) : $urandom;
      if ($urandom_range(0, 9) == 0) rq = $urandom;
      lg = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
      send_request(CMD_ALLOC, rq, lg, $urandom, 0, '0);
    end
  endtask

  initial begin
    logic [31:0] pools[6];
    pools = '{32'd65536, 32'd1, 32'd4096, 32'hFFFF_FFFF, 32'd300, 32'h8000_0001};
    table_reset(PoolReset);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);
    foreach (dir_tbl[i])
      send_request(dir_tbl[i].cmd, dir_tbl[i].rq, dir_tbl[i].lg, dir_tbl[i].bo,
                   dir_tbl[i].has_exp, dir_tbl[i].res);
    drain();
    foreach (pools[p]) begin
      write_pool(pools[p]);
      for (int n = 0; n < 220; n++) begin
        random_request(pools[p] != 32'hFFFF_FFFF && pools[p] != 32'h8000_0001);
        if (n == 100) begin
          in_valid_i <= 0;
          while (pending_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end
    $display("ran %0d directed and %0d random requests over %0d pool sizes, %0d results",
             dir_tbl.size(), 6 * 220, 6, n_seen);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("first_fit_block_allocator: match");
    end else begin
      $display("%0d mismatches", n_err);
      $display("first_fit_block_allocator: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
